// ===== src/crcfr_pkg.sv =====
// Shared types, constants and the CRC byte function of the CRC-16 frame receiver.
package crcfr_pkg;

  // Frame header bytes.
  localparam logic [7:0] HDR_FIRST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'h55;

  // CRC-16 settings: polynomial 0x8005, MSB first, no reflection, no final xor.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h8005;

  // Width of the pulse period quotient and of the divider step counter.
  localparam int unsigned QUO_W     = 16;
  localparam int unsigned DIV_CNT_W = 4;

  // Saturated pulse period for a zero magnitude.
  localparam logic [QUO_W-1:0] PERIOD_SAT = 16'hFFFF;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_NUMERATOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_CODE      = 1'b1;

  // Frame status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

  // One completed frame as handed from the parser to the result stage.
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  command;
    logic [31:0] parameter_val;
    logic [15:0] rx_crc;
    logic [15:0] calc_crc;
  } frame_rec_t;

  // Advance the CRC over one byte, eight shift steps.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== src/crc16_frame_receiver_unit.sv =====
// Top level of the CRC-16 checked serial frame receiver.
//
// Received bytes enter on the in channel (valid/ready, rx_byte_i), one per
// cycle. A parser hunts for the header 0xAA 0x55, collects the command, four
// little-endian parameter bytes and a CRC sent low byte first, and checks the
// CRC-16 over the first seven bytes. Each completed frame is placed in a short
// queue; the result stage pops it, forms the magnitude and divides the speed
// numerator by it, one quotient bit per cycle, then holds one item on the out
// channel until it is taken.
// A bad, unknown or zero-parameter frame goes from the queue straight to the
// out register; a speed frame first passes through the 16-step divider, and
// the result stage takes no new frame until the last one has been taken.
// Bytes are taken every cycle except that the last byte of a
// frame waits while the queue is full, so a stalled receiver holds the input
// only at frame ends.
// Reset clears the parser to hunting, empties the queue and restores the
// configuration defaults (numerator 37500, speed command 1).
module crc16_frame_receiver_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [crcfr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [crcfr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      rx_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      frame_status_o,
  output logic [7:0]                      command_o,
  output logic signed [31:0]              parameter_res_o,
  output logic                            reverse_o,
  output logic [31:0]                     magnitude_o,
  output logic [15:0]                     pulse_period_o,
  output logic                            divide_by_zero_o,
  output logic [15:0]                     received_crc_o,
  output logic [15:0]                     computed_crc_o
);
  import crcfr_pkg::*;

  logic [15:0] speed_numerator_q;
  logic [7:0]  speed_code_q;

  logic        push_valid;
  logic        push_ready;
  frame_rec_t  push_rec;
  logic        pop_valid;
  logic        pop_ready;
  frame_rec_t  pop_rec;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_numerator_q <= 16'd37500;
      speed_code_q      <= 8'h01;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SPEED_NUMERATOR: speed_numerator_q <= cfg_wdata_i;
        CFG_SPEED_CODE:      speed_code_q      <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  crcfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .speed_code_i (speed_code_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_rec_o   (push_rec)
  );

  crcfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_rec_i   (push_rec),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_rec_o    (pop_rec)
  );

  crcfr_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .pop_valid_i       (pop_valid),
    .pop_ready_o       (pop_ready),
    .pop_rec_i         (pop_rec),
    .speed_numerator_i (speed_numerator_q),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .frame_status_o    (frame_status_o),
    .command_o         (command_o),
    .parameter_res_o   (parameter_res_o),
    .reverse_o         (reverse_o),
    .magnitude_o       (magnitude_o),
    .pulse_period_o    (pulse_period_o),
    .divide_by_zero_o  (divide_by_zero_o),
    .received_crc_o    (received_crc_o),
    .computed_crc_o    (computed_crc_o)
  );

endmodule

// ===== src/crcfr_front.sv =====
// Byte parser: header hunt, field capture, CRC accumulation and frame classification.
module crcfr_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           rx_byte_i,
  input  logic [7:0]           speed_code_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output crcfr_pkg::frame_rec_t push_rec_o
);
  import crcfr_pkg::*;

  typedef enum logic [3:0] {
    PH_HUNT, PH_HDR2, PH_CMD, PH_P0, PH_P1, PH_P2, PH_P3, PH_CRCL, PH_CRCH
  } phase_e;

  phase_e      phase_q;
  logic [15:0] crc_q;
  logic [7:0]  cmd_q;
  logic [31:0] param_q;
  logic [7:0]  crcl_q;
  logic        accept;
  logic [15:0] rx_crc;

  // The last CRC byte is only taken when the queue has room for the frame.
  assign in_ready_o   = (phase_q != PH_CRCH) || push_ready_i;
  assign push_valid_o = in_valid_i && (phase_q == PH_CRCH);
  assign accept       = in_valid_i && in_ready_o;

  // Classify the frame as its final byte arrives.
  assign rx_crc = {rx_byte_i, crcl_q};
  always_comb begin
    push_rec_o.command       = cmd_q;
    push_rec_o.parameter_val = param_q;
    push_rec_o.rx_crc        = rx_crc;
    push_rec_o.calc_crc      = crc_q;
    if (rx_crc != crc_q) begin
      push_rec_o.status = STATUS_CRC_ERR;
    end else if (cmd_q == speed_code_i) begin
      push_rec_o.status = STATUS_OK;
    end else begin
      push_rec_o.status = STATUS_UNKNOWN;
    end
  end

  // Frame phase sequencer with the captured fields.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      crc_q   <= CRC_INIT;
      cmd_q   <= '0;
      param_q <= '0;
      crcl_q  <= '0;
    end else if (accept) begin
      unique case (phase_q)
        PH_HDR2: begin
          if (rx_byte_i == HDR_SECOND) begin
            crc_q   <= crc_byte(crc_q, rx_byte_i);
            phase_q <= PH_CMD;
          end else begin
            phase_q <= PH_HUNT;
          end
        end
        PH_CMD: begin
          cmd_q   <= rx_byte_i;
          crc_q   <= crc_byte(crc_q, rx_byte_i);
          phase_q <= PH_P0;
        end
        PH_P0, PH_P1, PH_P2, PH_P3: begin
          // Little-endian: each byte enters at the top and moves down.
          param_q <= {rx_byte_i, param_q[31:8]};
          crc_q   <= crc_byte(crc_q, rx_byte_i);
          phase_q <= (phase_q == PH_P3) ? PH_CRCL : phase_e'(phase_q + 4'd1);
        end
        PH_CRCL: begin
          crcl_q  <= rx_byte_i;
          phase_q <= PH_CRCH;
        end
        PH_CRCH: begin
          phase_q <= PH_HUNT;
        end
        default: begin
          // Hunting; the CRC restarts from the first header byte.
          if (rx_byte_i == HDR_FIRST) begin
            crc_q   <= crc_byte(CRC_INIT, HDR_FIRST);
            phase_q <= PH_HDR2;
          end else begin
            phase_q <= PH_HUNT;
          end
        end
      endcase
    end
  end

endmodule

// ===== src/crcfr_queue.sv =====
// Short frame queue between the parser and the result stage.
module crcfr_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  crcfr_pkg::frame_rec_t push_rec_i,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output crcfr_pkg::frame_rec_t pop_rec_o
);
  import crcfr_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  frame_rec_t     mem_q [DEPTH];
  logic [AW-1:0]  wr_ptr_q;
  logic [AW-1:0]  rd_ptr_q;
  logic [CW-1:0]  count_q;
  logic           do_push;
  logic           do_pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_rec_o    = mem_q[rd_ptr_q];

  // Storage; entries are only read after they are written.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

// ===== src/crcfr_back.sv =====
// Result stage: magnitude, bit-serial pulse period division and the output register.
module crcfr_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pop_valid_i,
  output logic                  pop_ready_o,
  input  crcfr_pkg::frame_rec_t pop_rec_i,
  input  logic [15:0]           speed_numerator_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            frame_status_o,
  output logic [7:0]            command_o,
  output logic signed [31:0]    parameter_res_o,
  output logic                  reverse_o,
  output logic [31:0]           magnitude_o,
  output logic [15:0]           pulse_period_o,
  output logic                  divide_by_zero_o,
  output logic [15:0]           received_crc_o,
  output logic [15:0]           computed_crc_o
);
  import crcfr_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_OUT} state_e;

  state_e               state_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [QUO_W-1:0]     rem_q;
  logic [QUO_W-1:0]     quo_q;
  logic [1:0]           status_q;
  logic [7:0]           cmd_q;
  logic [31:0]          param_q;
  logic                 rev_q;
  logic [31:0]          mag_q;
  logic                 zero_q;
  logic [15:0]          rxcrc_q;
  logic [15:0]          calc_q;

  logic                 is_neg;
  logic [31:0]          mag_in;
  logic [QUO_W:0]       trial;
  logic                 fits;

  assign pop_ready_o = (state_q == ST_IDLE);

  // Absolute value of the incoming parameter.
  assign is_neg = pop_rec_i.parameter_val[31];
  assign mag_in = is_neg ? (~pop_rec_i.parameter_val + 32'd1) : pop_rec_i.parameter_val;

  // One restoring division step: the partial remainder never exceeds the numerator.
  assign trial = {rem_q, quo_q[QUO_W-1]};
  assign fits  = ({15'd0, trial} >= mag_q);

  // Sequencer with the result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      rem_q    <= '0;
      quo_q    <= '0;
      status_q <= '0;
      cmd_q    <= '0;
      param_q  <= '0;
      rev_q    <= 1'b0;
      mag_q    <= '0;
      zero_q   <= 1'b0;
      rxcrc_q  <= '0;
      calc_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (pop_valid_i) begin
            status_q <= pop_rec_i.status;
            cmd_q    <= pop_rec_i.command;
            param_q  <= pop_rec_i.parameter_val;
            rxcrc_q  <= pop_rec_i.rx_crc;
            calc_q   <= pop_rec_i.calc_crc;
            rem_q    <= '0;
            cnt_q    <= '0;
            if (pop_rec_i.status != STATUS_OK) begin
              // Speed fields stay zero outside a good speed frame.
              rev_q   <= 1'b0;
              mag_q   <= '0;
              zero_q  <= 1'b0;
              quo_q   <= '0;
              state_q <= ST_OUT;
            end else if (mag_in == '0) begin
              rev_q   <= 1'b0;
              mag_q   <= '0;
              zero_q  <= 1'b1;
              quo_q   <= PERIOD_SAT;
              state_q <= ST_OUT;
            end else begin
              rev_q   <= is_neg;
              mag_q   <= mag_in;
              zero_q  <= 1'b0;
              quo_q   <= speed_numerator_i;
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          // Numerator bits leave the top of quo_q as quotient bits enter below.
          if (fits) begin
            rem_q <= trial[QUO_W-1:0] - mag_q[QUO_W-1:0];
          end else begin
            rem_q <= trial[QUO_W-1:0];
          end
          quo_q <= {quo_q[QUO_W-2:0], fits};
          cnt_q <= cnt_q + DIV_CNT_W'(1);
          if (cnt_q == DIV_CNT_W'(QUO_W - 1)) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = (state_q == ST_OUT);
  assign frame_status_o   = status_q;
  assign command_o        = cmd_q;
  assign parameter_res_o  = param_q;
  assign reverse_o        = rev_q;
  assign magnitude_o      = mag_q;
  assign pulse_period_o   = quo_q;
  assign divide_by_zero_o = zero_q;
  assign received_crc_o   = rxcrc_q;
  assign computed_crc_o   = calc_q;

endmodule

// ===== src/crcfr_checker.sv =====
// Port-level checks on the frame receiver results, bound to the top level.
module crcfr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [1:0]                      frame_status_o,
  input logic [7:0]                      command_o,
  input logic signed [31:0]              parameter_res_o,
  input logic                            reverse_o,
  input logic [31:0]                     magnitude_o,
  input logic [15:0]                     pulse_period_o,
  input logic                            divide_by_zero_o,
  input logic [15:0]                     received_crc_o,
  input logic [15:0]                     computed_crc_o
);
  import crcfr_pkg::*;

  // A presented item stays until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(command_o))
    else $error("result item dropped while stalled");

  // The status reports a CRC mismatch exactly when the two CRCs differ.
  a_crc_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((frame_status_o == STATUS_CRC_ERR) == (received_crc_o != computed_crc_o)))
    else $error("status disagrees with the CRC comparison");

  // Speed fields are zero outside a good speed frame.
  a_speed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_status_o != STATUS_OK) |->
      !reverse_o && (magnitude_o == '0) && (pulse_period_o == '0) && !divide_by_zero_o)
    else $error("speed fields set on a frame that is not a good speed frame");

  // Zero magnitude saturates the period; direction follows the sign.
  a_speed_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_status_o == STATUS_OK) |->
      (reverse_o == parameter_res_o[31]) &&
      (divide_by_zero_o == (magnitude_o == '0)) &&
      (!divide_by_zero_o || (pulse_period_o == PERIOD_SAT)))
    else $error("direction or zero flag inconsistent with the parameter");

endmodule

bind crc16_frame_receiver_unit crcfr_checker u_crcfr_checker (.*);
